// ===== hw/rtl/lprt_pkg.sv =====
// Shared types and constants for the longest-prefix route table.
// Holds the route entry layout, operation codes, status codes and the prefix mask helper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lprt_pkg;

  // Fixed field widths of the route table.
  localparam int AddrBits = 32;
  localparam int IdW      = 5;
  localparam int PfxW     = 6;
  localparam int MetricW  = 16;
  localparam int IfW      = 4;
  localparam int TypeW    = 4;
  localparam int StatW    = 2;
  localparam int ModeW    = 3;

  // Metric given to added routes that carry a zero metric, until the register is written.
  localparam logic [MetricW-1:0] ResetMetric = 16'd30;

  // Operation codes of an input beat.
  typedef enum logic [ModeW-1:0] {
    MODE_ADD        = 3'd0,
    MODE_LOOKUP     = 3'd1,
    MODE_SET_NET    = 3'd2,
    MODE_SET_HOP    = 3'd3,
    MODE_SET_PFX    = 3'd4,
    MODE_SET_METRIC = 3'd5,
    MODE_READ       = 3'd6
  } mode_e;

  // Status codes of a result beat.
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_NONE  = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatW-1:0] ST_INVAL = 2'd3;

  // One stored route.
  typedef struct packed {
    logic [IfW-1:0]      iface;
    logic [TypeW-1:0]    atype;
    logic [AddrBits-1:0] network;
    logic [AddrBits-1:0] next_hop;
    logic [PfxW-1:0]     prefix;
    logic [MetricW-1:0]  metric;
  } entry_t;

  // Mask that keeps the leading prefix bits of an address.
  function automatic logic [AddrBits-1:0] prefix_mask(input logic [PfxW-1:0] pfx);
    logic [PfxW-1:0] len;
    logic [PfxW-1:0] sh;
    len = (pfx > PfxW'(AddrBits)) ? PfxW'(AddrBits) : pfx;
    sh  = PfxW'(AddrBits) - len;
    if (len == '0) begin
      return '0;
    end
    return {AddrBits{1'b1}} << sh;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lprt_pick.sv =====
// Candidate test for one lookup step of the route table.
// Decides whether a route read from the table replaces the best match held so far.
// Depends on lprt_pkg for the entry layout and the prefix mask.
`default_nettype none

module lprt_pick (
  input  lprt_pkg::entry_t               entry_i,
  input  lprt_pkg::entry_t               best_i,
  input  logic                           found_i,
  input  logic [lprt_pkg::TypeW-1:0]     addr_type_i,
  input  logic [lprt_pkg::IfW-1:0]       iface_id_i,
  input  logic                           iface_given_i,
  input  logic [lprt_pkg::AddrBits-1:0]  address_i,
  output logic                           take_o
);
  import lprt_pkg::*;

  logic match;
  logic better;

  // The route matches when type, optional interface and leading prefix bits agree.
  assign match = (entry_i.atype == addr_type_i) &&
                 (!iface_given_i || (entry_i.iface == iface_id_i)) &&
                 (((entry_i.network ^ address_i) & prefix_mask(entry_i.prefix)) == '0);

  // A longer prefix wins; on an equal prefix a lower or equal metric wins.
  assign better = !found_i ||
                  (entry_i.prefix > best_i.prefix) ||
                  ((entry_i.prefix == best_i.prefix) && (entry_i.metric <= best_i.metric));

  assign take_o = match && better;

endmodule

`default_nettype wire

// ===== hw/rtl/longest_prefix_route_table_core.sv =====
// Longest-prefix-match route table: route memory, operation sequencer and result register.
// Depends on lprt_pkg and instantiates lprt_pick for the lookup comparison.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat: add, lookup,
//   set network, set next hop, set prefix, set metric or read. Every operation gives
//   exactly one result beat on the output channel (out_valid_o / out_stall_i).
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the default
//   metric; it is always ready and should be written only while the table is idle.
//   Routes live in a memory with one write port and one registered read port. The block works on
//   one operation at a time and stalls the input until that operation is finished.
//   Add, bad id and unused codes go from idle straight to the done state; set and read
//   operations pass through the read-modify-write state first (read, modify and write back);
//   a lookup walks the stored routes in the scan state, reading one route per cycle from the
//   memory port, then goes to the done state, which hands the result to the output register.
//   A finished result waits in a holding register while the output register is stalled;
//   the next input beat is accepted once it has moved on, even while the output waits.
//   Reset empties the table (the route count clears) and restores the default metric of 30;
//   the memory itself is not cleared, since only stored routes are ever used.
`default_nettype none

module longest_prefix_route_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lprt_pkg::MetricW-1:0]   cfg_data_i,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lprt_pkg::ModeW-1:0]     mode_i,
  input  logic [lprt_pkg::IdW-1:0]       route_id_i,
  input  logic [lprt_pkg::IfW-1:0]       iface_id_i,
  input  logic                           iface_given_i,
  input  logic [lprt_pkg::TypeW-1:0]     addr_type_i,
  input  logic [lprt_pkg::AddrBits-1:0]  address_i,
  input  logic [lprt_pkg::AddrBits-1:0]  next_hop_in_i,
  input  logic [lprt_pkg::PfxW-1:0]      prefix_in_i,
  input  logic [lprt_pkg::MetricW-1:0]   metric_in_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lprt_pkg::StatW-1:0]     status_o,
  output logic [lprt_pkg::IdW-1:0]       hit_id_o,
  output logic [lprt_pkg::IfW-1:0]       hit_iface_o,
  output logic [lprt_pkg::TypeW-1:0]     hit_type_o,
  output logic [lprt_pkg::AddrBits-1:0]  hit_network_o,
  output logic [lprt_pkg::AddrBits-1:0]  hit_next_hop_o,
  output logic [lprt_pkg::PfxW-1:0]      hit_prefix_o,
  output logic [lprt_pkg::MetricW-1:0]   hit_metric_o
);
  import lprt_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int CmpW = (CntW > IdW) ? CntW : IdW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } state_e;

  // Operation held while it is worked on.
  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [IfW-1:0]      iface;
    logic                iface_given;
    logic [TypeW-1:0]    atype;
    logic [AddrBits-1:0] address;
    logic [AddrBits-1:0] next_hop;
    logic [PfxW-1:0]     prefix;
    logic [MetricW-1:0]  metric;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   id;
    entry_t           ent;
  } res_t;

  // Route id reported for a memory index.
  function automatic logic [IdW-1:0] id_of(input logic [IdxW-1:0] idx);
    logic [IdxW:0] t;
    t = {1'b0, idx} + 1'b1;
    return IdW'(t);
  endfunction

  state_e                state_q, state_d;
  req_t                  req_q, req_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       ptr_q, ptr_d;
  logic                  found_q, found_d;
  entry_t                best_q, best_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  res_t                  res_q, res_d;
  res_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [MetricW-1:0]    default_q;

  entry_t                mem [ENTRIES];
  entry_t                rdata_q;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [IdxW-1:0]       mem_raddr;
  entry_t                mem_wdata;

  entry_t                ent_new;
  entry_t                ent_mod;
  logic                  take;
  logic                  last;

  // Route built from an add beat.
  assign ent_new = '{iface:    iface_id_i,
                     atype:    addr_type_i,
                     network:  address_i,
                     next_hop: next_hop_in_i,
                     prefix:   prefix_in_i,
                     metric:   (metric_in_i == '0) ? default_q : metric_in_i};

  // Route after a per-entry write; an out-of-range prefix leaves it as it was.
  always_comb begin
    ent_mod = rdata_q;
    case (mode_e'(req_q.mode))
      MODE_SET_NET:    ent_mod.network  = req_q.address;
      MODE_SET_HOP:    ent_mod.next_hop = req_q.next_hop;
      MODE_SET_PFX: begin
        if (req_q.prefix <= PfxW'(AddrBits)) begin
          ent_mod.prefix = req_q.prefix;
        end
      end
      MODE_SET_METRIC: ent_mod.metric   = req_q.metric;
      default:         ent_mod = rdata_q;
    endcase
  end

  // Lookup comparison for the route read in this cycle.
  lprt_pick u_pick (
    .entry_i       (rdata_q),
    .best_i        (best_q),
    .found_i       (found_q),
    .addr_type_i   (req_q.atype),
    .iface_id_i    (req_q.iface),
    .iface_given_i (req_q.iface_given),
    .address_i     (req_q.address),
    .take_o        (take)
  );

  assign last = ((CntW'(ptr_q) + 1'b1) == cnt_q);

  // Sequencer next-state logic and memory port control.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = ent_mod;
    mem_raddr   = IdxW'(ptr_q + 1'b1);

    // The output register empties when its beat is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (mode_e'(mode_i) == MODE_LOOKUP) begin
          mem_raddr = '0;
        end else begin
          mem_raddr = IdxW'(route_id_i - 1'b1);
        end
        if (in_valid_i) begin
          req_d = '{mode:        mode_i,
                    iface:       iface_id_i,
                    iface_given: iface_given_i,
                    atype:       addr_type_i,
                    address:     address_i,
                    next_hop:    next_hop_in_i,
                    prefix:      prefix_in_i,
                    metric:      metric_in_i};
          state_d = S_DONE;
          case (mode_e'(mode_i))
            MODE_ADD: begin
              if (cnt_q == CntW'(ENTRIES)) begin
                res_d = '{status: ST_FULL, id: '0, ent: '0};
              end else if (prefix_in_i > PfxW'(AddrBits)) begin
                res_d = '{status: ST_INVAL, id: '0, ent: '0};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IdxW'(cnt_q);
                mem_wdata = ent_new;
                cnt_d     = cnt_q + 1'b1;
                res_d     = '{status: ST_OK, id: id_of(IdxW'(cnt_q)), ent: ent_new};
              end
            end
            MODE_LOOKUP: begin
              found_d = 1'b0;
              ptr_d   = '0;
              if (cnt_q == '0) begin
                res_d = '{status: ST_NONE, id: '0, ent: '0};
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_SET_NET, MODE_SET_HOP, MODE_SET_PFX, MODE_SET_METRIC, MODE_READ: begin
              if ((route_id_i == '0) || (CmpW'(route_id_i) > CmpW'(cnt_q))) begin
                res_d = '{status: ST_NONE, id: '0, ent: '0};
              end else begin
                ptr_d   = IdxW'(route_id_i - 1'b1);
                state_d = S_RMW;
              end
            end
            default: begin
              res_d = '{status: ST_INVAL, id: '0, ent: '0};
            end
          endcase
        end
      end

      // The addressed route is in rdata_q: update, write back (except for a read) and report it.
      S_RMW: begin
        mem_we    = (mode_e'(req_q.mode) != MODE_READ);
        mem_waddr = ptr_q;
        mem_wdata = ent_mod;
        if ((mode_e'(req_q.mode) == MODE_SET_PFX) && (req_q.prefix > PfxW'(AddrBits))) begin
          res_d = '{status: ST_INVAL, id: id_of(ptr_q), ent: ent_mod};
        end else begin
          res_d = '{status: ST_OK, id: id_of(ptr_q), ent: ent_mod};
        end
        state_d = S_DONE;
      end

      // One route per cycle arrives from the memory; the next read is already issued.
      S_SCAN: begin
        if (take) begin
          found_d    = 1'b1;
          best_d     = rdata_q;
          best_idx_d = ptr_q;
        end
        if (last) begin
          if (take) begin
            res_d = '{status: ST_OK, id: id_of(ptr_q), ent: rdata_q};
          end else if (found_q) begin
            res_d = '{status: ST_OK, id: id_of(best_idx_q), ent: best_q};
          end else begin
            res_d = '{status: ST_NONE, id: '0, ent: '0};
          end
          state_d = S_DONE;
        end else begin
          ptr_d = IdxW'(ptr_q + 1'b1);
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_idx_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      default_q   <= ResetMetric;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        default_q <= cfg_data_i;
      end
    end
  end

  // Route memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Port drive.
  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign hit_id_o       = out_q.id;
  assign hit_iface_o    = out_q.ent.iface;
  assign hit_type_o     = out_q.ent.atype;
  assign hit_network_o  = out_q.ent.network;
  assign hit_next_hop_o = out_q.ent.next_hop;
  assign hit_prefix_o   = out_q.ent.prefix;
  assign hit_metric_o   = out_q.ent.metric;

  // The route count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(ENTRIES) >= cnt_q)
    else $error("route count exceeds table size");

  // A reported prefix length is always within the address width.
  a_pfx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_prefix_o <= PfxW'(AddrBits)))
    else $error("reported prefix length out of range");

  // An accepted beat always starts work, so the sequencer leaves idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start an operation");

  // A lookup scan stays within the stored routes.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(ptr_q) < cnt_q))
    else $error("lookup scan beyond stored routes");

endmodule

`default_nettype wire
